// ===== sv/fppc_pkg.sv =====
package fppc_pkg;

    // Widths of counters and fields
    localparam int COUNTER_BITS   = 32;
    localparam int STAT_W         = 32;
    localparam int DUR_W          = 16;
    localparam int TEMP_W         = 12;
    localparam int HYST_W         = 11;
    localparam int MSEC_W         = 6;
    localparam int MINUTE_SECONDS = 60;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;

    // Command codes
    localparam logic [2:0] CMD_TICK      = 3'd0;
    localparam logic [2:0] CMD_SET_MODE  = 3'd1;
    localparam logic [2:0] CMD_SET_CTRL  = 3'd2;
    localparam logic [2:0] CMD_CLR_FAULT = 3'd3;
    localparam logic [2:0] CMD_CLR_STATS = 3'd4;

    // Pump modes
    localparam logic [1:0] MODE_DISABLED   = 2'd0;
    localparam logic [1:0] MODE_MANUAL_ON  = 2'd1;
    localparam logic [1:0] MODE_MANUAL_OFF = 2'd2;
    localparam logic [1:0] MODE_AUTO       = 2'd3;

    // Fault causes
    localparam logic [1:0] CAUSE_NONE     = 2'd0;
    localparam logic [1:0] CAUSE_LOW_FLOW = 2'd1;
    localparam logic [1:0] CAUSE_RUNTIME  = 2'd2;
    localparam logic [1:0] CAUSE_NO_FLOW  = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FREEZE_THRESHOLD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FREEZE_HYSTERESIS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ON_DURATION       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_DURATION      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ON_TIME       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FLOW_TIMEOUT      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSES        = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_AUTO_ALLOWED      = 3'd7;

    typedef struct packed {
        logic [2:0]               command;
        logic [1:0]               mode;
        logic                     enable;
        logic                     manual_request;
        logic signed [TEMP_W-1:0] temperature;
        logic [DUR_W-1:0]         new_pulses;
    } t_in_item;

    typedef struct packed {
        logic              pump_on;
        logic              fault;
        logic [1:0]        fault_cause;
        logic              state_changed;
        logic [STAT_W-1:0] on_seconds;
        logic [STAT_W-1:0] off_seconds;
        logic [STAT_W-1:0] start_count;
        logic [STAT_W-1:0] pulse_total;
    } t_out_item;

    typedef struct packed {
        logic signed [TEMP_W-1:0] freeze_threshold;
        logic [HYST_W-1:0]        freeze_hysteresis;
        logic [DUR_W-1:0]         on_duration;
        logic [DUR_W-1:0]         off_duration;
        logic [DUR_W-1:0]         max_on_time;
        logic [DUR_W-1:0]         flow_timeout;
        logic [DUR_W-1:0]         min_pulses_per_minute;
        logic                     auto_allowed;
    } t_cfg;

endpackage

// ===== sv/fppc_cfg.sv =====
module fppc_cfg
    import fppc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    // Always take a register write
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Decode the index and load the register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.freeze_threshold      <= TEMP_W'(32);
            r_cfg.freeze_hysteresis     <= HYST_W'(32);
            r_cfg.on_duration           <= DUR_W'(300);
            r_cfg.off_duration          <= DUR_W'(300);
            r_cfg.max_on_time           <= DUR_W'(3600);
            r_cfg.flow_timeout          <= DUR_W'(30);
            r_cfg.min_pulses_per_minute <= '0;
            r_cfg.auto_allowed          <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_FREEZE_THRESHOLD:  r_cfg.freeze_threshold  <= i_cfg_data[TEMP_W-1:0];
                REG_FREEZE_HYSTERESIS: r_cfg.freeze_hysteresis <= i_cfg_data[HYST_W-1:0];
                REG_ON_DURATION:       r_cfg.on_duration       <= i_cfg_data[DUR_W-1:0];
                REG_OFF_DURATION:      r_cfg.off_duration      <= i_cfg_data[DUR_W-1:0];
                REG_MAX_ON_TIME:       r_cfg.max_on_time       <= i_cfg_data[DUR_W-1:0];
                REG_FLOW_TIMEOUT:      r_cfg.flow_timeout      <= i_cfg_data[DUR_W-1:0];
                REG_MIN_PULSES:  r_cfg.min_pulses_per_minute <= i_cfg_data[DUR_W-1:0];
                REG_AUTO_ALLOWED:      r_cfg.auto_allowed      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

endmodule

// ===== sv/fppc_ctrl.sv =====
module fppc_ctrl
    import fppc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_result
);

    // Controller state
    logic [1:0]              r_mode, n_mode;
    logic                    r_en, n_en;
    logic                    r_ml, n_ml;
    logic                    r_running, n_running;
    logic                    r_fault, n_fault;
    logic                    r_freeze, n_freeze;
    logic                    r_phase_on, n_phase_on;
    logic [DUR_W-1:0]        r_phase_sec, n_phase_sec;
    logic [DUR_W-1:0]        r_cont_on, n_cont_on;
    logic [DUR_W-1:0]        r_since_pulse, n_since_pulse;
    logic [DUR_W-1:0]        r_min_pulses, n_min_pulses;
    logic [MSEC_W-1:0]       r_min_sec, n_min_sec;
    logic [COUNTER_BITS-1:0] r_on_cnt, n_on_cnt;
    logic [COUNTER_BITS-1:0] r_off_cnt, n_off_cnt;
    logic [COUNTER_BITS-1:0] r_start_cnt, n_start_cnt;
    logic [COUNTER_BITS-1:0] r_pulse_cnt, n_pulse_cnt;

    // Working values
    logic [1:0]              raised;
    logic                    do_eval;
    logic [DUR_W:0]          mp_sum;
    logic [COUNTER_BITS:0]   pc_sum;
    logic [MSEC_W-1:0]       ms_inc;
    logic [DUR_W:0]          ps_inc;
    logic [DUR_W-1:0]        lim;
    logic signed [TEMP_W:0]  temp_x;
    logic signed [TEMP_W:0]  thr_x;
    logic signed [TEMP_W:0]  thr_hi;

    assign temp_x = {i_item.temperature[TEMP_W-1], i_item.temperature};
    assign thr_x  = {i_cfg.freeze_threshold[TEMP_W-1], i_cfg.freeze_threshold};
    assign thr_hi = thr_x + $signed({2'b00, i_cfg.freeze_hysteresis});

    always_comb begin
        n_mode        = r_mode;
        n_en          = r_en;
        n_ml          = r_ml;
        n_running     = r_running;
        n_fault       = r_fault;
        n_freeze      = r_freeze;
        n_phase_on    = r_phase_on;
        n_phase_sec   = r_phase_sec;
        n_cont_on     = r_cont_on;
        n_since_pulse = r_since_pulse;
        n_min_pulses  = r_min_pulses;
        n_min_sec     = r_min_sec;
        n_on_cnt      = r_on_cnt;
        n_off_cnt     = r_off_cnt;
        n_start_cnt   = r_start_cnt;
        n_pulse_cnt   = r_pulse_cnt;
        raised        = CAUSE_NONE;
        do_eval       = 1'b0;
        mp_sum        = {1'b0, r_min_pulses} + {1'b0, i_item.new_pulses};
        pc_sum        = {1'b0, r_pulse_cnt} + (COUNTER_BITS+1)'(i_item.new_pulses);
        ms_inc        = r_min_sec + MSEC_W'(1);
        ps_inc        = '0;
        lim           = '0;

        // Command specific work ahead of the pump evaluation
        case (i_item.command)
            CMD_TICK: begin
                if (i_item.new_pulses != '0) begin
                    n_since_pulse = '0;
                    n_min_pulses  = mp_sum[DUR_W] ? '1 : mp_sum[DUR_W-1:0];
                    n_pulse_cnt   = pc_sum[COUNTER_BITS] ? '1
                                                         : pc_sum[COUNTER_BITS-1:0];
                end else if (r_since_pulse != '1) begin
                    n_since_pulse = r_since_pulse + DUR_W'(1);
                end
                // Close the minute window and check the pulse rate
                if (ms_inc >= MSEC_W'(MINUTE_SECONDS) || ms_inc == '0) begin
                    if (r_running && i_cfg.min_pulses_per_minute != '0 &&
                        n_min_pulses < i_cfg.min_pulses_per_minute && !n_fault) begin
                        n_fault = 1'b1;
                        raised  = CAUSE_LOW_FLOW;
                    end
                    n_min_sec    = '0;
                    n_min_pulses = '0;
                end else begin
                    n_min_sec = ms_inc;
                end
                do_eval = 1'b1;
            end
            CMD_SET_MODE: begin
                if (i_item.mode != r_mode) begin
                    n_phase_on  = 1'b0;
                    n_freeze    = 1'b0;
                    n_phase_sec = '0;
                    n_cont_on   = '0;
                end
                n_mode  = i_item.mode;
                do_eval = 1'b1;
            end
            CMD_SET_CTRL: begin
                n_en    = i_item.enable;
                n_ml    = i_item.manual_request;
                do_eval = 1'b1;
            end
            CMD_CLR_FAULT: begin
                n_fault       = 1'b0;
                n_since_pulse = '0;
                n_min_pulses  = '0;
                n_min_sec     = '0;
                n_cont_on     = '0;
            end
            CMD_CLR_STATS: begin
                n_on_cnt      = '0;
                n_off_cnt     = '0;
                n_start_cnt   = '0;
                n_pulse_cnt   = '0;
                n_phase_sec   = '0;
                n_cont_on     = '0;
                n_since_pulse = '0;
                n_min_pulses  = '0;
                n_min_sec     = '0;
            end
            default: ;
        endcase

        // Evaluate the pump drive
        if (do_eval) begin
            if (n_fault) begin
                n_running   = 1'b0;
                n_phase_on  = 1'b0;
                n_freeze    = 1'b0;
                n_phase_sec = '0;
            end else begin
                case (n_mode)
                    MODE_MANUAL_ON: n_running = n_en & n_ml;
                    MODE_AUTO: begin
                        if (!n_en || !i_cfg.auto_allowed) begin
                            n_running   = 1'b0;
                            n_phase_on  = 1'b0;
                            n_freeze    = 1'b0;
                            n_phase_sec = '0;
                        end else begin
                            // Enter or leave freeze protection with hysteresis
                            if (!n_freeze && temp_x <= thr_x) begin
                                n_freeze    = 1'b1;
                                n_phase_on  = 1'b1;
                                n_phase_sec = '0;
                            end else if (n_freeze && temp_x > thr_hi) begin
                                n_freeze    = 1'b0;
                                n_phase_on  = 1'b0;
                                n_phase_sec = '0;
                            end
                            if (!n_freeze) begin
                                n_running = 1'b0;
                            end else begin
                                // Advance the on/off cycle timer
                                ps_inc    = {1'b0, n_phase_sec} + (DUR_W+1)'(1);
                                lim       = n_phase_on ? i_cfg.on_duration
                                                       : i_cfg.off_duration;
                                if (lim == '0) begin
                                    lim = DUR_W'(1);
                                end
                                n_running = n_phase_on;
                                if (ps_inc >= {1'b0, lim}) begin
                                    n_phase_on  = !n_phase_on;
                                    n_phase_sec = '0;
                                end else begin
                                    n_phase_sec = ps_inc[DUR_W-1:0];
                                end
                            end
                        end
                    end
                    default: n_running = 1'b0;
                endcase
                // Trip on excessive continuous runtime
                if (n_running && n_cont_on >= i_cfg.max_on_time) begin
                    n_running = 1'b0;
                    n_fault   = 1'b1;
                    raised    = CAUSE_RUNTIME;
                end
            end
            if (!r_running && n_running && n_start_cnt != '1) begin
                n_start_cnt = n_start_cnt + COUNTER_BITS'(1);
            end
        end

        // No-flow check and run-time statistics on a tick
        if (i_item.command == CMD_TICK) begin
            if (n_running && i_cfg.flow_timeout != '0 &&
                n_since_pulse >= i_cfg.flow_timeout && !n_fault) begin
                n_fault   = 1'b1;
                raised    = CAUSE_NO_FLOW;
                n_running = 1'b0;
            end
            if (n_running) begin
                if (n_on_cnt != '1) begin
                    n_on_cnt = n_on_cnt + COUNTER_BITS'(1);
                end
                n_cont_on = n_cont_on + DUR_W'(1);
            end else begin
                if (n_off_cnt != '1) begin
                    n_off_cnt = n_off_cnt + COUNTER_BITS'(1);
                end
                n_cont_on = '0;
            end
        end
    end

    // Result of this item
    always_comb begin
        o_result.pump_on       = n_running;
        o_result.fault         = n_fault;
        o_result.fault_cause   = raised;
        o_result.state_changed = n_running != r_running;
        o_result.on_seconds    = STAT_W'(n_on_cnt);
        o_result.off_seconds   = STAT_W'(n_off_cnt);
        o_result.start_count   = STAT_W'(n_start_cnt);
        o_result.pulse_total   = STAT_W'(n_pulse_cnt);
    end

    // Commit the state when the item moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_DISABLED;
            r_en          <= 1'b0;
            r_ml          <= 1'b0;
            r_running     <= 1'b0;
            r_fault       <= 1'b0;
            r_freeze      <= 1'b0;
            r_phase_on    <= 1'b0;
            r_phase_sec   <= '0;
            r_cont_on     <= '0;
            r_since_pulse <= '0;
            r_min_pulses  <= '0;
            r_min_sec     <= '0;
            r_on_cnt      <= '0;
            r_off_cnt     <= '0;
            r_start_cnt   <= '0;
            r_pulse_cnt   <= '0;
        end else if (i_fire) begin
            r_mode        <= n_mode;
            r_en          <= n_en;
            r_ml          <= n_ml;
            r_running     <= n_running;
            r_fault       <= n_fault;
            r_freeze      <= n_freeze;
            r_phase_on    <= n_phase_on;
            r_phase_sec   <= n_phase_sec;
            r_cont_on     <= n_cont_on;
            r_since_pulse <= n_since_pulse;
            r_min_pulses  <= n_min_pulses;
            r_min_sec     <= n_min_sec;
            r_on_cnt      <= n_on_cnt;
            r_off_cnt     <= n_off_cnt;
            r_start_cnt   <= n_start_cnt;
            r_pulse_cnt   <= n_pulse_cnt;
        end
    end

endmodule

// ===== sv/freeze_protect_pump_controller_top.sv =====
// Freeze-protect pump controller.
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one command per
// transfer: a one-second tick with temperature and flow pulses, set mode,
// set controls, clear fault or clear statistics. Every command gives exactly
// one result on the output channel (o_out_valid / i_out_ready / o_out_data):
// pump drive, fault flag and cause, drive change and the four statistics.
// Configuration port (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data)
// is always ready; write it only while no command is in flight.
// A command taken into the input register is evaluated by combinational
// logic and moves into the result register as soon as that register is free
// or being read; o_out_valid then presents its result.
// Throughput: one command per cycle while the receiver takes every result;
// the evaluation between the input and result registers is combinational.
// When the receiver stalls, the result register holds its result and the
// input register holds one more command; o_in_ready falls once both are full.
// Reset (i_rst_n low, synchronous) clears the pump state, faults, timers and
// statistics, empties both registers and loads the register defaults.
module freeze_protect_pump_controller_top
    import fppc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    logic      adv;
    t_cfg      cfg;
    t_out_item result;

    // Move the held command into the result register when it is free
    assign adv        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;

    fppc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    fppc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (adv),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A fault raised by a result is always latched in the same result
    a_cause_latched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.fault_cause == CAUSE_NONE || o_out_data.fault))
        else $error("fault cause reported without latched fault");

    // An evaluated command always produces a valid result next cycle
    a_adv_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> r_out_valid)
        else $error("evaluated command lost its result");

    // An empty result register never blocks the input
    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_in_ready)
        else $error("input stalled with free result register");

endmodule

// ===== verif/tb_freeze_protect_pump_controller_top.sv =====
`timescale 1ns / 100ps

module tb_freeze_protect_pump_controller_top;
    import fppc_pkg::*;

    // Command codes the block must ignore
    localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
    localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

    localparam int IDLE_PCT    = 6;
    localparam int HOLD_CYCLES = 60;
    localparam int CALM_TICKS  = 200;
    localparam int RAND_PHASES = 10;
    localparam int PHASE_ITEMS = 50;
    localparam int MAX_PRINTS  = 40;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in_item              i_in_data;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_out_item             o_out_data;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    freeze_protect_pump_controller_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Shadow settings and pump state
    t_cfg              cfg_shadow;
    logic [1:0]        pm_mode;
    logic              pm_enabled;
    logic              pm_manual;
    logic              pm_running;
    logic              pm_fault;
    logic              pm_freeze;
    logic              pm_phase_on;
    logic [31:0]       pm_phase_secs;
    logic [31:0]       pm_run_secs;
    logic [31:0]       pm_dry_secs;
    logic [31:0]       pm_win_pulses;
    logic [MSEC_W-1:0] pm_win_secs;
    logic [31:0]       st_on;
    logic [31:0]       st_off;
    logic [31:0]       st_starts;
    logic [31:0]       st_pulses;
    logic [1:0]        pm_raised;

    t_out_item status_q[$];
    int        fail_count      = 0;
    int        items_sent      = 0;
    int        results_checked = 0;
    int        cfg_writes      = 0;
    int        faults_by_cause[4];
    int        hold_left       = 0;
    bit        calm            = 1'b0;

    // ------------------------------------------------------------------
    // Pump status predictor
    // ------------------------------------------------------------------
    function automatic logic [31:0] bump(input logic [31:0] v);
        return (v == '1) ? v : v + 32'd1;
    endfunction

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [15:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {17'd0, b};
        return s[32] ? '1 : s[31:0];
    endfunction

    task automatic reset_pump_state();
        cfg_shadow.freeze_threshold      = 12'sd32;
        cfg_shadow.freeze_hysteresis     = 11'd32;
        cfg_shadow.on_duration           = 16'd300;
        cfg_shadow.off_duration          = 16'd300;
        cfg_shadow.max_on_time           = 16'd3600;
        cfg_shadow.flow_timeout          = 16'd30;
        cfg_shadow.min_pulses_per_minute = 16'd0;
        cfg_shadow.auto_allowed          = 1'b1;
        pm_mode       = MODE_DISABLED;
        pm_enabled    = 1'b0;
        pm_manual     = 1'b0;
        pm_running    = 1'b0;
        pm_fault      = 1'b0;
        pm_freeze     = 1'b0;
        pm_phase_on   = 1'b0;
        pm_phase_secs = '0;
        pm_run_secs   = '0;
        pm_dry_secs   = '0;
        pm_win_pulses = '0;
        pm_win_secs   = '0;
        st_on         = '0;
        st_off        = '0;
        st_starts     = '0;
        st_pulses     = '0;
    endtask

    task automatic apply_setting(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] d);
        case (idx)
            REG_FREEZE_THRESHOLD:  cfg_shadow.freeze_threshold      = d[TEMP_W-1:0];
            REG_FREEZE_HYSTERESIS: cfg_shadow.freeze_hysteresis     = d[HYST_W-1:0];
            REG_ON_DURATION:       cfg_shadow.on_duration           = d;
            REG_OFF_DURATION:      cfg_shadow.off_duration          = d;
            REG_MAX_ON_TIME:       cfg_shadow.max_on_time           = d;
            REG_FLOW_TIMEOUT:      cfg_shadow.flow_timeout          = d;
            REG_MIN_PULSES:        cfg_shadow.min_pulses_per_minute = d;
            REG_AUTO_ALLOWED:      cfg_shadow.auto_allowed          = d[0];
            default: ;
        endcase
    endtask

    // First fault latches; the cause is reported once per command
    task automatic latch_fault(input logic [1:0] cause);
        if (!pm_fault) begin
            pm_fault = 1'b1;
            if (pm_raised == CAUSE_NONE) begin
                pm_raised = cause;
                faults_by_cause[cause]++;
            end
        end
    endtask

    task automatic park_auto();
        pm_phase_on   = 1'b0;
        pm_freeze     = 1'b0;
        pm_phase_secs = '0;
    endtask

    task automatic evaluate_drive(input int temp);
        logic        was;
        logic [31:0] limit;
        int          thr;
        int          hyst;
        was  = pm_running;
        thr  = $signed(cfg_shadow.freeze_threshold);
        hyst = cfg_shadow.freeze_hysteresis;
        if (pm_fault) begin
            pm_running = 1'b0;
            park_auto();
        end else begin
            case (pm_mode)
                MODE_MANUAL_ON: pm_running = pm_enabled && pm_manual;
                MODE_AUTO: begin
                    if (!pm_enabled || !cfg_shadow.auto_allowed) begin
                        pm_running = 1'b0;
                        park_auto();
                    end else begin
                        // Enter or leave freeze protection with hysteresis
                        if (!pm_freeze && temp <= thr) begin
                            pm_freeze     = 1'b1;
                            pm_phase_on   = 1'b1;
                            pm_phase_secs = '0;
                        end else if (pm_freeze && temp > thr + hyst) begin
                            pm_freeze     = 1'b0;
                            pm_phase_on   = 1'b0;
                            pm_phase_secs = '0;
                        end
                        if (!pm_freeze) begin
                            pm_running = 1'b0;
                        end else begin
                            // Advance the on/off cycle; zero duration acts as one
                            pm_phase_secs = bump(pm_phase_secs);
                            limit = pm_phase_on ? {16'd0, cfg_shadow.on_duration}
                                                : {16'd0, cfg_shadow.off_duration};
                            if (limit == 32'd0) begin
                                limit = 32'd1;
                            end
                            pm_running = pm_phase_on;
                            if (pm_phase_secs >= limit) begin
                                pm_phase_on   = !pm_phase_on;
                                pm_phase_secs = '0;
                            end
                        end
                    end
                end
                default: pm_running = 1'b0;
            endcase
            if (pm_running && pm_run_secs >= cfg_shadow.max_on_time) begin
                pm_running = 1'b0;
                latch_fault(CAUSE_RUNTIME);
            end
        end
        if (!was && pm_running) begin
            st_starts = bump(st_starts);
        end
    endtask

    task automatic account_flow(input logic [15:0] pulses);
        if (pulses != 0) begin
            pm_dry_secs   = '0;
            pm_win_pulses = sat_add(pm_win_pulses, pulses);
            st_pulses     = sat_add(st_pulses, pulses);
        end else begin
            pm_dry_secs = bump(pm_dry_secs);
        end
        // Close the minute window, checking flow against the drive before evaluation
        pm_win_secs = pm_win_secs + 1'b1;
        if (pm_win_secs >= MINUTE_SECONDS || pm_win_secs == 0) begin
            if (pm_running && cfg_shadow.min_pulses_per_minute > 0 &&
                pm_win_pulses < cfg_shadow.min_pulses_per_minute) begin
                latch_fault(CAUSE_LOW_FLOW);
            end
            pm_win_secs   = '0;
            pm_win_pulses = '0;
        end
    endtask

    task automatic predict_status(input t_in_item c, output t_out_item st);
        logic was;
        int   temp;
        was       = pm_running;
        temp      = $signed(c.temperature);
        pm_raised = CAUSE_NONE;
        case (c.command)
            CMD_TICK: begin
                account_flow(c.new_pulses);
                evaluate_drive(temp);
                if (pm_running && cfg_shadow.flow_timeout > 0 &&
                    pm_dry_secs >= cfg_shadow.flow_timeout && !pm_fault) begin
                    latch_fault(CAUSE_NO_FLOW);
                    pm_running = 1'b0;
                end
                if (pm_running) begin
                    st_on       = bump(st_on);
                    pm_run_secs = bump(pm_run_secs);
                end else begin
                    st_off      = bump(st_off);
                    pm_run_secs = '0;
                end
            end
            CMD_SET_MODE: begin
                if (c.mode != pm_mode) begin
                    park_auto();
                    pm_run_secs = '0;
                end
                pm_mode = c.mode;
                evaluate_drive(temp);
            end
            CMD_SET_CTRL: begin
                pm_enabled = c.enable;
                pm_manual  = c.manual_request;
                evaluate_drive(temp);
            end
            CMD_CLR_FAULT: begin
                pm_fault      = 1'b0;
                pm_dry_secs   = '0;
                pm_win_pulses = '0;
                pm_win_secs   = '0;
                pm_run_secs   = '0;
            end
            CMD_CLR_STATS: begin
                st_on         = '0;
                st_off        = '0;
                st_starts     = '0;
                st_pulses     = '0;
                pm_phase_secs = '0;
                pm_run_secs   = '0;
                pm_dry_secs   = '0;
                pm_win_pulses = '0;
                pm_win_secs   = '0;
            end
            default: ;
        endcase
        st.pump_on       = pm_running;
        st.fault         = pm_fault;
        st.fault_cause   = pm_raised;
        st.state_changed = (pm_running != was);
        st.on_seconds    = st_on;
        st.off_seconds   = st_off;
        st.start_count   = st_starts;
        st.pulse_total   = st_pulses;
    endtask

    // ------------------------------------------------------------------
    // Result checking and receiver stalls
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= MAX_PRINTS) begin
            $display("[%0t] MISMATCH %s", $time, msg);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v) begin
            report_mismatch($sformatf("result %0d %s: expected 0x%0h, got 0x%0h",
                                      results_checked, name, want_v, got_v));
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready) begin
            if (status_q.size() == 0) begin
                report_mismatch("result arrived with no command outstanding");
            end else begin
                want = status_q.pop_front();
                check_field("pump_on", 32'(want.pump_on), 32'(o_out_data.pump_on));
                check_field("fault", 32'(want.fault), 32'(o_out_data.fault));
                check_field("fault_cause", 32'(want.fault_cause),
                            32'(o_out_data.fault_cause));
                check_field("state_changed", 32'(want.state_changed),
                            32'(o_out_data.state_changed));
                check_field("on_seconds", want.on_seconds, o_out_data.on_seconds);
                check_field("off_seconds", want.off_seconds, o_out_data.off_seconds);
                check_field("start_count", want.start_count, o_out_data.start_count);
                check_field("pulse_total", want.pulse_total, o_out_data.pulse_total);
            end
            results_checked++;
        end
    end

    // Hold off for a requested stretch, otherwise stall at random
    always @(posedge i_clk) begin : receiver_stall
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left--;
        end else begin
            i_out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // Command and register traffic
    // ------------------------------------------------------------------
    task automatic issue(input t_in_item c);
        t_out_item st;
        if (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= c;
        do @(posedge i_clk); while (!o_in_ready);
        predict_status(c, st);
        status_q.push_back(st);
        items_sent++;
    endtask

    // Drop valid and wait until every outstanding result has arrived
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (status_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] d);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        apply_setting(idx, d);
        cfg_writes++;
    endtask

    function automatic t_in_item make_cmd(input logic [2:0] code, input logic [1:0] md,
                                          input logic en, input logic man,
                                          input int temp, input int pulses);
        t_in_item c;
        c.command        = code;
        c.mode           = md;
        c.enable         = en;
        c.manual_request = man;
        c.temperature    = temp[TEMP_W-1:0];
        c.new_pulses     = pulses[DUR_W-1:0];
        return c;
    endfunction

    task automatic tick(input int temp, input int pulses);
        issue(make_cmd(CMD_TICK, MODE_DISABLED, 1'b0, 1'b0, temp, pulses));
    endtask

    task automatic set_mode(input logic [1:0] md, input int temp);
        issue(make_cmd(CMD_SET_MODE, md, 1'b0, 1'b0, temp, 0));
    endtask

    task automatic set_ctrl(input logic en, input logic man, input int temp);
        issue(make_cmd(CMD_SET_CTRL, MODE_DISABLED, en, man, temp, 0));
    endtask

    task automatic plain(input logic [2:0] code);
        issue(make_cmd(code, MODE_DISABLED, 1'b0, 1'b0, 0, 0));
    endtask

    // Temperature around the freeze band, sometimes anywhere in range
    function automatic int pick_temp();
        int thr;
        int t;
        thr = $signed(cfg_shadow.freeze_threshold);
        if ($urandom_range(99) < 20) begin
            t = int'($urandom_range(4095)) - 2048;
        end else begin
            t = thr - 24 + int'($urandom_range(int'(cfg_shadow.freeze_hysteresis) + 48));
        end
        if (t > 2047) t = 2047;
        if (t < -2048) t = -2048;
        return t;
    endfunction

    function automatic t_in_item random_cmd();
        t_in_item c;
        int       r;
        c.mode           = ($urandom_range(1) != 0) ? MODE_AUTO : 2'($urandom_range(3));
        c.enable         = ($urandom_range(3) != 0);
        c.manual_request = 1'($urandom_range(1));
        c.temperature    = TEMP_W'(pick_temp());
        r = $urandom_range(99);
        if (r < 25) c.new_pulses = '0;
        else if (r < 80) c.new_pulses = 16'($urandom_range(1, 4));
        else if (r < 95) c.new_pulses = 16'($urandom_range(65535));
        else c.new_pulses = '1;
        r = $urandom_range(99);
        if (r < 65) c.command = CMD_TICK;
        else if (r < 75) c.command = CMD_SET_MODE;
        else if (r < 85) c.command = CMD_SET_CTRL;
        else if (r < 91) c.command = CMD_CLR_FAULT;
        else if (r < 94) c.command = CMD_CLR_STATS;
        else if (r < 97) c.command = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
        else c.command = CMD_TICK;
        return c;
    endfunction

    function automatic logic [15:0] pick_duration(input int lo, input int hi);
        int r;
        r = $urandom_range(9);
        if (r == 0) return 16'd0;
        if (r == 1) return 16'hFFFF;
        return 16'($urandom_range(lo, hi));
    endfunction

    // Write every register, extremes included; unused upper data bits random
    task automatic randomize_settings();
        logic [15:0] d;
        int          r;
        d = 16'($urandom);
        r = $urandom_range(5);
        if (r == 0) d[11:0] = 12'h800;
        else if (r == 1) d[11:0] = 12'h7FF;
        else d[11:0] = 12'($urandom_range(200)) - 12'd100;
        cfg_write(REG_FREEZE_THRESHOLD, d);
        d = 16'($urandom);
        r = $urandom_range(5);
        if (r == 0) d[10:0] = '0;
        else if (r == 1) d[10:0] = '1;
        else d[10:0] = 11'($urandom_range(40));
        cfg_write(REG_FREEZE_HYSTERESIS, d);
        cfg_write(REG_ON_DURATION, pick_duration(1, 6));
        cfg_write(REG_OFF_DURATION, pick_duration(1, 6));
        cfg_write(REG_MAX_ON_TIME, pick_duration(5, 60));
        cfg_write(REG_FLOW_TIMEOUT, pick_duration(1, 8));
        cfg_write(REG_MIN_PULSES,
                  ($urandom_range(2) == 0) ? pick_duration(1, 50) : 16'd0);
        d = 16'($urandom);
        d[0] = ($urandom_range(4) != 0);
        cfg_write(REG_AUTO_ALLOWED, d);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_basic_commands();
        logic [2:0] code;
        // Unknown commands report status only
        for (code = CMD_UNUSED_LO; code != CMD_UNUSED_HI; code++) plain(code);
        plain(CMD_UNUSED_HI);
        tick(0, 0);
        tick(2047, 65535);
        tick(-2048, 1);
        set_ctrl(1'b1, 1'b1, 0);
        set_mode(MODE_MANUAL_ON, 0);
        tick(0, 5);
        tick(0, 5);
        set_mode(MODE_MANUAL_OFF, 0);
        set_mode(MODE_AUTO, -2048);
        tick(-2048, 3);
        tick(2047, 3);
        set_mode(MODE_DISABLED, 0);
        plain(CMD_CLR_FAULT);
        plain(CMD_CLR_STATS);
        set_ctrl(1'b0, 1'b0, 0);
        set_ctrl(1'b0, 1'b1, 0);
        set_ctrl(1'b1, 1'b0, 0);
    endtask

    task automatic test_runtime_fault();
        // Zero max run time faults on any attempt to run
        cfg_write(REG_MAX_ON_TIME, 16'd0);
        set_ctrl(1'b1, 1'b1, 0);
        set_mode(MODE_MANUAL_ON, 0);
        plain(CMD_CLR_FAULT);
        tick(0, 2);
        cfg_write(REG_MAX_ON_TIME, 16'd3);
        plain(CMD_CLR_FAULT);
        repeat (6) tick(0, 2);
        plain(CMD_CLR_FAULT);
        cfg_write(REG_MAX_ON_TIME, 16'hFFFF);
    endtask

    task automatic test_no_flow();
        cfg_write(REG_FLOW_TIMEOUT, 16'd2);
        plain(CMD_CLR_FAULT);
        repeat (4) tick(0, 0);
        // Zero timeout disables the check
        cfg_write(REG_FLOW_TIMEOUT, 16'd0);
        plain(CMD_CLR_FAULT);
        repeat (5) tick(0, 0);
    endtask

    task automatic test_low_flow();
        // Low flow and runtime both due at the window end: low flow wins
        cfg_write(REG_MIN_PULSES, 16'hFFFF);
        cfg_write(REG_MAX_ON_TIME, 16'd59);
        plain(CMD_CLR_FAULT);
        plain(CMD_CLR_STATS);
        repeat (62) tick(0, 100);
        cfg_write(REG_MIN_PULSES, 16'd10);
        cfg_write(REG_MAX_ON_TIME, 16'hFFFF);
        plain(CMD_CLR_FAULT);
        repeat (61) tick(0, 1);
        cfg_write(REG_MIN_PULSES, 16'd0);
    endtask

    task automatic test_auto_cycling();
        int i;
        cfg_write(REG_FREEZE_THRESHOLD, 16'd0);
        cfg_write(REG_FREEZE_HYSTERESIS, 16'd16);
        cfg_write(REG_ON_DURATION, 16'd0);
        cfg_write(REG_OFF_DURATION, 16'd0);
        set_ctrl(1'b1, 1'b0, 20);
        set_mode(MODE_AUTO, 20);
        repeat (6) tick(-5, 2);
        tick(10, 2);
        tick(16, 2);
        tick(17, 2);
        tick(0, 2);
        cfg_write(REG_ON_DURATION, 16'd3);
        cfg_write(REG_OFF_DURATION, 16'd2);
        for (i = 0; i < 12; i++) tick(-1, 2);
        // Auto not allowed parks the pump
        cfg_write(REG_AUTO_ALLOWED, 16'd0);
        repeat (3) tick(-1, 2);
        cfg_write(REG_AUTO_ALLOWED, 16'hFFFF);
        set_ctrl(1'b1, 1'b0, -1);
        repeat (3) tick(-1, 2);
        // Threshold and hysteresis at their extremes, long durations
        cfg_write(REG_FREEZE_THRESHOLD, 16'hF800);
        cfg_write(REG_FREEZE_HYSTERESIS, 16'hFFFF);
        cfg_write(REG_ON_DURATION, 16'hFFFF);
        cfg_write(REG_OFF_DURATION, 16'hFFFF);
        tick(-2048, 2);
        tick(-1, 2);
        tick(0, 2);
        tick(-2048, 2);
        cfg_write(REG_FREEZE_THRESHOLD, 16'h07FF);
        cfg_write(REG_FREEZE_HYSTERESIS, 16'd0);
        tick(2047, 2);
        tick(2047, 2);
        tick(-2048, 2);
        set_mode(MODE_MANUAL_OFF, 0);
    endtask

    task automatic test_backpressure();
        // Long receiver hold-off while commands keep coming
        wait_drained();
        hold_left = HOLD_CYCLES;
        repeat (20) tick(pick_temp(), 1);
        // Pause the sender until every result is in
        wait_drained();
        repeat (10) tick(pick_temp(), 1);
    endtask

    task automatic test_full_rate();
        // Run a long stretch of large-pulse ticks without idling on either side
        set_mode(MODE_DISABLED, 0);
        plain(CMD_CLR_STATS);
        calm = 1'b1;
        repeat (CALM_TICKS) tick(pick_temp(), 65535);
        calm = 1'b0;
        plain(CMD_CLR_STATS);
    endtask

    task automatic test_random_traffic();
        int p;
        int n;
        for (p = 0; p < RAND_PHASES; p++) begin
            randomize_settings();
            plain(CMD_CLR_FAULT);
            set_ctrl(1'b1, 1'($urandom_range(1)), pick_temp());
            set_mode(MODE_AUTO, pick_temp());
            for (n = 0; n < PHASE_ITEMS; n++) issue(random_cmd());
        end
    endtask

    // Watchdog
    initial begin
        #1000000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_out_ready <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        reset_pump_state();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_basic_commands();
        test_runtime_fault();
        test_no_flow();
        test_low_flow();
        test_auto_cycling();
        test_backpressure();
        test_full_rate();
        test_random_traffic();

        wait_drained();
        repeat (4) @(posedge i_clk);
        $display("Sent %0d commands, checked %0d results, made %0d register writes.",
                 items_sent, results_checked, cfg_writes);
        $display("Faults raised: low flow %0d, runtime %0d, no flow %0d.",
                 faults_by_cause[CAUSE_LOW_FLOW], faults_by_cause[CAUSE_RUNTIME],
                 faults_by_cause[CAUSE_NO_FLOW]);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
